FILE: rtl/arpc_pkg.sv
// Shared types and constants of the ARP responder with its address cache.
package arpc_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] KIND_PKT    = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_INSERT = 2'd2;

   // Response kinds carried on rsp_tuser bit 0.
   localparam logic RES_REPLY  = 1'b0;
   localparam logic RES_LOOKUP = 1'b1;

   // Payload layout, as byte offsets into the ARP payload.
   localparam logic [4:0] HDR_END   = 5'd8;
   localparam logic [4:0] SMAC_END  = 5'd14;
   localparam logic [4:0] SIP_END   = 5'd18;
   localparam logic [4:0] TIP_START = 5'd24;
   localparam logic [4:0] PKT_LEN   = 5'd28;

   // Fixed header values of an ARP packet for IPv4 over Ethernet.
   localparam logic [15:0] HTYPE_ETH  = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  HLEN_MAC   = 8'd6;
   localparam logic [7:0]  PLEN_IP    = 8'd4;
   localparam logic [15:0] OPER_REQ   = 16'd1;
   localparam logic [15:0] OPER_REP   = 16'd2;

   // Commands passed from the front end to the cache engine.
   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_PACKET = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic        reply;
      logic [31:0] ip;
      logic [47:0] mac;
   } cmd_type;

   // Status of the command queue as seen by the cache engine.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

FILE: rtl/arpc_front.sv
// Front end: accepts request words, assembles ARP payloads and issues cache commands.
module arpc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   input  logic               in_fire,
   input  logic [1:0]         in_kind,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic [31:0]        in_ip,
   input  logic [47:0]        in_mac,
   output logic               push,
   output arpc_pkg::cmd_type  push_cmd
);

   logic [31:0] local_ip_ff;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [63:0] header_ff, header_in;
   logic [47:0] smac_ff, smac_in;
   logic [31:0] sip_ff, sip_in;
   logic [31:0] tip_ff, tip_in;
   logic        pkt_ok;

   always_comb begin
      byte_count_in = byte_count_ff;
      header_in     = header_ff;
      smac_in       = smac_ff;
      sip_in        = sip_ff;
      tip_in        = tip_ff;
      push          = 1'b0;
      push_cmd      = '0;
      pkt_ok        = 1'b0;
      if (in_fire) begin
         unique case (in_kind)
            arpc_pkg::KIND_LOOKUP: begin
               push         = 1'b1;
               push_cmd.op  = arpc_pkg::CMD_LOOKUP;
               push_cmd.ip  = in_ip;
            end
            arpc_pkg::KIND_INSERT: begin
               push         = 1'b1;
               push_cmd.op  = arpc_pkg::CMD_INSERT;
               push_cmd.ip  = in_ip;
               push_cmd.mac = in_mac;
            end
            arpc_pkg::KIND_PKT: begin
               if (byte_count_ff < arpc_pkg::HDR_END) begin
                  header_in[{~byte_count_ff[2:0], 3'b000} +: 8] = in_byte;
               end else if (byte_count_ff < arpc_pkg::SMAC_END) begin
                  smac_in = {smac_ff[39:0], in_byte};
               end else if (byte_count_ff < arpc_pkg::SIP_END) begin
                  sip_in = {sip_ff[23:0], in_byte};
               end else if (byte_count_ff >= arpc_pkg::TIP_START &&
                            byte_count_ff < arpc_pkg::PKT_LEN) begin
                  tip_in = {tip_ff[23:0], in_byte};
               end
               if (byte_count_ff < arpc_pkg::PKT_LEN) begin
                  byte_count_in = byte_count_ff + 5'd1;
               end
               if (in_last) begin
                  pkt_ok = (byte_count_in >= arpc_pkg::PKT_LEN) &&
                           (header_in[63:48] == arpc_pkg::HTYPE_ETH) &&
                           (header_in[47:32] == arpc_pkg::PTYPE_IPV4) &&
                           (header_in[31:24] == arpc_pkg::HLEN_MAC) &&
                           (header_in[23:16] == arpc_pkg::PLEN_IP) &&
                           ((header_in[15:0] == arpc_pkg::OPER_REQ) ||
                            (header_in[15:0] == arpc_pkg::OPER_REP));
                  push           = pkt_ok;
                  push_cmd.op    = arpc_pkg::CMD_PACKET;
                  push_cmd.reply = (header_in[15:0] == arpc_pkg::OPER_REQ) &&
                                   (tip_in == local_ip_ff);
                  push_cmd.ip    = sip_in;
                  push_cmd.mac   = smac_in;
                  // Every packet, good or bad, leaves the assembly state clear.
                  byte_count_in  = '0;
                  header_in      = '0;
                  smac_in        = '0;
                  sip_in         = '0;
                  tip_in         = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff   <= '0;
         byte_count_ff <= '0;
         header_ff     <= '0;
         smac_ff       <= '0;
         sip_ff        <= '0;
         tip_ff        <= '0;
      end else begin
         if (csr_we) begin
            local_ip_ff <= csr_wdata;
         end
         byte_count_ff <= byte_count_in;
         header_ff     <= header_in;
         smac_ff       <= smac_in;
         sip_ff        <= sip_in;
         tip_ff        <= tip_in;
      end
   end

endmodule

FILE: rtl/arpc_fifo.sv
// Two-entry command queue between the front end and the cache engine.
module arpc_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  arpc_pkg::cmd_type        push_cmd,
   output logic                     not_full,
   output arpc_pkg::queue_head_type head,
   input  logic                     pop
);

   arpc_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full   = (count_ff != 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/arpc_back.sv
// Cache engine: runs queued commands against the address cache and drives the response word.
module arpc_back #(
   parameter int CACHE_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  arpc_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [79:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   localparam int IdxW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

   logic [31:0]            entry_ip_ff  [CACHE_DEPTH];
   logic [47:0]            entry_mac_ff [CACHE_DEPTH];
   logic [CACHE_DEPTH-1:0] entry_valid_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [47:0]            rsp_mac_ff, rsp_mac_in;
   logic [31:0]            rsp_ip_ff, rsp_ip_in;

   logic [CACHE_DEPTH-1:0] match;
   logic                   any_match, any_free;
   logic [IdxW-1:0]        match_idx, free_idx, wr_idx;
   logic                   need_rsp, do_insert;

   always_comb begin
      match     = '0;
      any_match = 1'b0;
      any_free  = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
         match[i] = entry_valid_ff[i] && (entry_ip_ff[i] == head.cmd.ip);
         if (match[i]) begin
            any_match = 1'b1;
            match_idx = IdxW'(i);
         end
         if (!entry_valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // Update in place, else first empty entry, else entry zero.
   assign wr_idx = any_match ? match_idx : (any_free ? free_idx : '0);

   assign need_rsp = (head.cmd.op == arpc_pkg::CMD_LOOKUP) ||
                     ((head.cmd.op == arpc_pkg::CMD_PACKET) && head.cmd.reply);
   assign pop = head.valid && (!need_rsp || !rsp_valid_ff || rsp_tready);
   assign do_insert = pop && (head.cmd.ip != 32'd0) &&
                      ((head.cmd.op == arpc_pkg::CMD_INSERT) ||
                       (head.cmd.op == arpc_pkg::CMD_PACKET));

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_mac_in   = rsp_mac_ff;
      rsp_ip_in    = rsp_ip_ff;
      if (pop && need_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_ip_in    = head.cmd.ip;
         if (head.cmd.op == arpc_pkg::CMD_LOOKUP) begin
            rsp_kind_in = arpc_pkg::RES_LOOKUP;
            rsp_hit_in  = any_match;
            rsp_mac_in  = any_match ? entry_mac_ff[match_idx] : '0;
         end else begin
            rsp_kind_in = arpc_pkg::RES_REPLY;
            rsp_hit_in  = 1'b1;
            rsp_mac_in  = head.cmd.mac;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         entry_ip_ff[wr_idx]  <= head.cmd.ip;
         entry_mac_ff[wr_idx] <= head.cmd.mac;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_ip_ff   <= rsp_ip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (do_insert) begin
            entry_valid_ff[wr_idx] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ip_ff, rsp_mac_ff};
   assign rsp_tuser  = {rsp_hit_ff, rsp_kind_ff};

endmodule

FILE: rtl/arp_responder_with_cache_top.sv
// Top level of the ARP responder with its IPv4-to-MAC address cache.
// Throughput: one request word per cycle, sustained while rsp_tready keeps up.
// With an empty queue, the request word of a lookup answer or ARP reply (the lookup or last
// payload byte) goes into a queue slot, then its answer into the register behind rsp_tvalid.
// A stalled response word blocks the next lookup or reply; the two-entry queue then fills.
// Synchronous active-high reset clears the queue, cache valid bits, packet state and local_ip.
module arp_responder_with_cache_top #(
   parameter int CACHE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: local_ip.
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // data_byte[7:0], addr_ip[39:8], addr_mac[87:40]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   input  logic        req_tlast,   // last_byte
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_mac[47:0], out_ip[79:48]
   output logic [1:0]  rsp_tuser    // result_kind[0], hit[1]
);

   logic                     in_fire;
   logic                     push;
   arpc_pkg::cmd_type        push_cmd;
   logic                     not_full;
   arpc_pkg::queue_head_type head;
   logic                     pop;

   // The front end takes a word whenever the queue has room, so a result waiting on the
   // response side does not hold up packet bytes until the queue itself fills.
   assign req_tready = not_full;
   assign in_fire    = req_tvalid && not_full;

   // Payload bytes are parsed here; lookups, inserts and valid finished packets become commands.
   arpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_fire   (in_fire),
      .in_kind   (req_tuser),
      .in_byte   (req_tdata[7:0]),
      .in_last   (req_tlast),
      .in_ip     (req_tdata[39:8]),
      .in_mac    (req_tdata[87:40]),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // The queue keeps command order, so cache reads and writes happen in request order.
   arpc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .not_full (not_full),
      .head     (head),
      .pop      (pop)
   );

   // All cache entries are compared in parallel against the command's IP.
   arpc_back #(
      .CACHE_DEPTH (CACHE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/arpc_checker.sv
// Port-level checks of the ARP responder, bound to its top level.
module arpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled response word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // Reset empties the response register and the command queue.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // A reply always reports a hit.
   a_reply_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == arpc_pkg::RES_REPLY) |-> rsp_tuser[1])
      else $error("reply without hit");

   // A lookup miss returns an all-zero MAC.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == arpc_pkg::RES_LOOKUP) && !rsp_tuser[1]
      |-> (rsp_tdata[47:0] == 48'd0))
      else $error("lookup miss with non-zero MAC");

endmodule

bind arp_responder_with_cache_top arpc_checker u_arpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
